FILE: hw/rtl/gscfc_pkg.sv
// gscfc_pkg: shared types, constants and the crc-8 byte update for the
// gas sensor response frame checker
// no dependencies
package gscfc_pkg;

  // crc-8 constants: polynomial x^8+x^5+x^4+1, msb first, no final xor
  localparam logic [7:0] CrcInit = 8'hFF;
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcMsb  = 8'h80;

  // byte position within a response frame
  typedef logic [2:0] pos_t;

  localparam pos_t PosData0  = 3'd0;  // first word, high byte
  localparam pos_t PosData1  = 3'd1;  // first word, low byte
  localparam pos_t PosCrc0   = 3'd2;  // crc of the first group
  localparam pos_t PosData2  = 3'd3;  // second word, high byte
  localparam pos_t PosData3  = 3'd4;  // second word, low byte
  localparam pos_t PosCrc1   = 3'd5;  // crc of the second group
  localparam pos_t FrameLast = PosCrc1;

  // one input transfer
  typedef struct packed {
    logic       frame_first;
    logic [7:0] rx_byte;
  } item_t;

  // one result transfer
  typedef struct packed {
    logic        frame_status;
    logic [15:0] tvoc_ppb;
    logic [15:0] eco2_ppm;
  } res_t;

  // feed one byte into the crc, eight bit steps
  function automatic logic [7:0] crc_feed(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcMsb) != 8'h00) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/gscfc_in_stage.sv
// gscfc_in_stage: input register for received bytes
// depends on gscfc_pkg for the item type
module gscfc_in_stage
  import gscfc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  item_valid_o,
  output item_t item_o,
  input  logic  item_take_i
);

  logic  valid_q;
  item_t item_q;

  // room when empty or when the held byte is consumed this cycle
  assign in_ready_o   = !valid_q || item_take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload capture on transfer
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

FILE: hw/rtl/gscfc_frame.sv
// gscfc_frame: byte position tracking, crc update and word capture
// depends on gscfc_pkg for types, constants and crc_feed
module gscfc_frame
  import gscfc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  item_valid_i,
  input  item_t item_i,
  input  logic  out_room_i,
  output logic  item_take_o,
  output logic  res_valid_o,
  output res_t  res_o
);

  pos_t        pos_q, pos_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] first_word_q, first_word_d;
  logic [7:0]  second_hi_q, second_hi_d;
  logic [7:0]  second_lo_q, second_lo_d;
  logic        first_ok_q, first_ok_d;

  logic        restart;
  pos_t        pos_eff;
  logic [7:0]  crc_base;
  logic        is_last;

  // a mark or an unused code starts the frame again
  assign restart  = item_i.frame_first || (pos_q > FrameLast);
  assign pos_eff  = restart ? PosData0 : pos_q;
  assign crc_base = restart ? CrcInit : crc_q;
  assign is_last  = (pos_eff == FrameLast);

  // the last byte waits only when the result register is full
  assign item_take_o = item_valid_i && (!is_last || out_room_i);
  assign res_valid_o = item_take_o && is_last;

  // result fields
  assign res_o.eco2_ppm     = first_word_q;
  assign res_o.tvoc_ppb     = {second_hi_q, second_lo_q};
  assign res_o.frame_status = !(first_ok_q && (crc_base == item_i.rx_byte));

  // next state per byte position
  always_comb begin
    pos_d        = pos_q;
    crc_d        = crc_q;
    first_word_d = first_word_q;
    second_hi_d  = second_hi_q;
    second_lo_d  = second_lo_q;
    first_ok_d   = first_ok_q;
    if (item_take_o) begin
      pos_d = pos_eff + 3'd1;
      unique case (pos_eff)
        PosData0: begin
          crc_d        = crc_feed(CrcInit, item_i.rx_byte);
          first_word_d = {item_i.rx_byte, 8'h00};
        end
        PosData1: begin
          crc_d        = crc_feed(crc_base, item_i.rx_byte);
          first_word_d = {first_word_q[15:8], item_i.rx_byte};
        end
        PosCrc0: begin
          first_ok_d = (crc_base == item_i.rx_byte);
          crc_d      = CrcInit;
        end
        PosData2: begin
          crc_d       = crc_feed(crc_base, item_i.rx_byte);
          second_hi_d = item_i.rx_byte;
        end
        PosData3: begin
          crc_d       = crc_feed(crc_base, item_i.rx_byte);
          second_lo_d = item_i.rx_byte;
        end
        default: begin
          // second group crc: frame complete
          pos_d = PosData0;
          crc_d = CrcInit;
        end
      endcase
    end
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= PosData0;
      crc_q        <= CrcInit;
      first_word_q <= 16'h0000;
      second_hi_q  <= 8'h00;
      second_lo_q  <= 8'h00;
      first_ok_q   <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      crc_q        <= crc_d;
      first_word_q <= first_word_d;
      second_hi_q  <= second_hi_d;
      second_lo_q  <= second_lo_d;
      first_ok_q   <= first_ok_d;
    end
  end

endmodule

FILE: hw/rtl/gscfc_out_stage.sv
// gscfc_out_stage: result register towards the master side
// depends on gscfc_pkg for the result type
module gscfc_out_stage
  import gscfc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_valid_i,
  input  res_t res_i,
  output logic out_room_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_res_o
);

  logic valid_q;
  res_t res_q;

  // a new result fits when empty or when the held one leaves now
  assign out_room_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_room_o) begin
      valid_q <= res_valid_i;
    end
  end

  // result capture
  always_ff @(posedge clk_i) begin
    if (res_valid_i && out_room_o) begin
      res_q <= res_i;
    end
  end

endmodule

FILE: hw/rtl/gas_sensor_crc_frame_checker.sv
// gas_sensor_crc_frame_checker: top level, checks six-byte sensor responses
// the sixth byte passes the input register and the crc check, and its result is registered before it is valid
// throughput: one byte per cycle while the result register has room, set by the combinational crc byte update
// a full result register stalls only the sixth byte, earlier bytes keep flowing
// reset: asynchronous, active low; position 0, crc ff, words and flags cleared
module gas_sensor_crc_frame_checker
  import gscfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic [0:0]  s_axis_tuser_i,   // [0] frame_first
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [15:0] eco2_ppm, [31:16] tvoc_ppb
  output logic [0:0]  m_axis_tuser_o    // [0] frame_status
);

  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  item_take;
  logic  out_room;
  logic  res_valid;
  res_t  res;
  res_t  out_res;

  // unpack the slave side
  assign in_item.rx_byte     = s_axis_tdata_i;
  assign in_item.frame_first = s_axis_tuser_i[0];

  // input register
  gscfc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  // frame tracking and crc
  gscfc_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .out_room_i   (out_room),
    .item_take_o  (item_take),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // result register
  gscfc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_room_o  (out_room),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (out_res)
  );

  // pack the master side
  assign m_axis_tdata_o = {out_res.tvoc_ppb, out_res.eco2_ppm};
  assign m_axis_tuser_o = out_res.frame_status;

endmodule

FILE: hw/rtl/gscfc_checker.sv
// gscfc_checker: port-level assertions for the frame checker
// bound to gas_sensor_crc_frame_checker; no package needed
module gscfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic [0:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [0:0]  m_axis_tuser_o
);

  logic s_xfer;
  assign s_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // the slave side only backs up behind a stalled result
  a_ready_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("slave side stalled without a stalled result");

  // a fresh result comes from a byte transfer that passed the input register and then the result register
  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_xfer, 2))
    else $error("result appeared without a matching byte transfer");

  // a stalled result holds its payload
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled result changed or dropped");

  // a waiting byte is held by the sender
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && !s_axis_tready_o) |=>
      (s_axis_tvalid_i && $stable(s_axis_tdata_i) && $stable(s_axis_tuser_i)))
    else $error("waiting byte changed or dropped");

endmodule

bind gas_sensor_crc_frame_checker gscfc_checker u_gscfc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
